// ===== hw/rtl/multilevel_ready_queue_scheduler_macros.svh =====
// assertion macros for the ready queue scheduler
// used by files that hold concurrent checks; expects i_clk and i_rst_n in scope
`ifndef MULTILEVEL_READY_QUEUE_SCHEDULER_MACROS_SVH
`define MULTILEVEL_READY_QUEUE_SCHEDULER_MACROS_SVH

// same-cycle implication
`define MRQS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mrqs check failed");

// next-cycle implication
`define MRQS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mrqs check failed");

`endif

// ===== hw/rtl/mrqs_pkg.sv =====
// shared types and codes for the ready queue scheduler
// no dependencies
package mrqs_pkg;

    localparam int IDW = 10;

    // request op codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_PICK   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BADLEVEL = 2'd1;
    localparam logic [1:0] STAT_NONE     = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    // row commands
    localparam logic [2:0] CMD_NOP       = 3'd0;
    localparam logic [2:0] CMD_LOAD      = 3'd1;
    localparam logic [2:0] CMD_MATCH     = 3'd2;
    localparam logic [2:0] CMD_PREFIX    = 3'd3;
    localparam logic [2:0] CMD_SHIFT_HIT = 3'd4;
    localparam logic [2:0] CMD_POP       = 3'd5;

    typedef struct packed {
        logic [1:0]     op;
        logic [IDW-1:0] task_id;
        logic [2:0]     level;
    } t_in;

    typedef struct packed {
        logic [1:0]     status;
        logic [IDW-1:0] chosen_id;
    } t_out;

    typedef struct packed {
        logic [2:0]     cmd;
        logic [IDW-1:0] id;
    } t_row_ctl;

endpackage

// ===== hw/rtl/mrqs_cell.sv =====
// one queue slot: holds an id and a match flag
// no dependencies
module mrqs_cell #(
    parameter int W = 10
) (
    input  logic         i_clk,
    input  logic         i_load,
    input  logic [W-1:0] i_load_id,
    input  logic         i_shift,
    input  logic [W-1:0] i_right_id,
    input  logic         i_hit_wr,
    input  logic         i_hit_d,
    output logic [W-1:0] o_id,
    output logic         o_hit
);

    logic [W-1:0] r_id;
    logic         r_hit;

    // slot data: pull from right neighbor or load at the tail
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_id <= i_right_id;
        end else if (i_load) begin
            r_id <= i_load_id;
        end
        if (i_hit_wr) begin
            r_hit <= i_hit_d;
        end
    end

    assign o_id  = r_id;
    assign o_hit = r_hit;

endmodule

// ===== hw/rtl/mrqs_row.sv =====
// one priority level: a chain of slot cells with a log-step match prefix
// depends on mrqs_pkg and mrqs_cell
module mrqs_row #(
    parameter int DEPTH = 64,
    parameter int SB    = 10,
    parameter int LENW  = 7,
    parameter int STEPS = 6,
    parameter int SW    = 3
) (
    input  logic              i_clk,
    input  logic              i_sel,
    input  mrqs_pkg::t_row_ctl i_ctl,
    input  logic [SW-1:0]     i_step,
    input  logic [LENW-1:0]   i_len,
    output logic [SB-1:0]     o_head,
    output logic              o_found
);

    logic [SB-1:0]    id_v [DEPTH];
    logic [DEPTH-1:0] hit_v;

    genvar i, s;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            logic [SB-1:0]    right_id;
            logic [STEPS-1:0] cand;
            logic             in_range;
            logic             load;
            logic             shift;
            logic             hit_wr;
            logic             hit_d;

            // neighbor data
            if (i == DEPTH - 1) begin : g_last
                assign right_id = '0;
            end else begin : g_mid
                assign right_id = id_v[i+1];
            end

            // hit flags at distance 2^s to the left
            for (s = 0; s < STEPS; s++) begin : g_cand
                if (i >= (1 << s)) begin : g_has
                    assign cand[s] = hit_v[i-(1<<s)];
                end else begin : g_none
                    assign cand[s] = 1'b0;
                end
            end

            assign in_range = LENW'(i) < i_len;
            assign load     = i_sel && (i_ctl.cmd == mrqs_pkg::CMD_LOAD) && (i_len == LENW'(i));
            assign shift    = i_sel && ((i_ctl.cmd == mrqs_pkg::CMD_POP) ||
                              ((i_ctl.cmd == mrqs_pkg::CMD_SHIFT_HIT) && hit_v[i]));
            assign hit_wr   = i_sel && ((i_ctl.cmd == mrqs_pkg::CMD_MATCH) ||
                              (i_ctl.cmd == mrqs_pkg::CMD_PREFIX));
            assign hit_d    = (i_ctl.cmd == mrqs_pkg::CMD_MATCH) ?
                              ((id_v[i] == i_ctl.id[SB-1:0]) && in_range) :
                              (hit_v[i] | cand[i_step]);

            mrqs_cell #(.W(SB)) u_cell (
                .i_clk      (i_clk),
                .i_load     (load),
                .i_load_id  (i_ctl.id[SB-1:0]),
                .i_shift    (shift),
                .i_right_id (right_id),
                .i_hit_wr   (hit_wr),
                .i_hit_d    (hit_d),
                .o_id       (id_v[i]),
                .o_hit      (hit_v[i])
            );
        end
    endgenerate

    assign o_head  = id_v[0];
    assign o_found = hit_v[DEPTH-1];

endmodule

// ===== hw/rtl/multilevel_ready_queue_scheduler.sv =====
// Ready queue scheduler, one FIFO of task ids per priority level held as a chain of slot cells.
// Add and pick pass through the EXEC and DONE states before the result valid is raised;
// remove also runs the PREFIX and SHIFT states (match prefix runs one doubling step a cycle).
// One request at a time: a new request is taken only once the sequencer is back in IDLE.
// Reset clears lengths, served counts and control; slot contents need no clearing.
// depends on mrqs_pkg, mrqs_row and the assertion macro header
`include "multilevel_ready_queue_scheduler_macros.svh"
module multilevel_ready_queue_scheduler #(
    parameter int LEVELS      = 5,
    parameter int QUEUE_DEPTH = 64,
    parameter int ID_BITS     = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mrqs_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output mrqs_pkg::t_out o_out
);

    localparam int SB    = (ID_BITS < mrqs_pkg::IDW) ? ID_BITS : mrqs_pkg::IDW;
    localparam int LW    = $clog2(LEVELS);
    localparam int LENW  = $clog2(QUEUE_DEPTH + 1);
    localparam int STEPS = $clog2(QUEUE_DEPTH);
    localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_PREFIX = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]      r_state, n_state;
    logic [1:0]      r_op;
    logic [SB-1:0]   r_id;
    logic [2:0]      r_lvl;
    logic [SW-1:0]   r_step, n_step;
    logic [LENW-1:0] r_len [LEVELS];
    logic [LENW-1:0] n_len [LEVELS];
    logic [LENW-1:0] r_served [LEVELS];
    logic [LENW-1:0] n_served [LEVELS];
    mrqs_pkg::t_out  r_res, n_res;
    mrqs_pkg::t_out  r_out;
    logic            r_ovalid, n_ovalid;

    mrqs_pkg::t_row_ctl row_ctl;
    logic [LEVELS-1:0]  row_sel;
    logic [SB-1:0]      heads [LEVELS];
    logic [LEVELS-1:0]  found;

    logic          lvl_ok;
    logic [LW-1:0] lvl_idx;
    logic          p1_hit, p2_hit, pick_any;
    logic [LW-1:0] p1_lvl, p2_lvl, pick_lvl;

    assign lvl_ok  = {1'b0, r_lvl} < 4'(LEVELS);
    assign lvl_idx = r_lvl[LW-1:0];

    // pick search, both passes side by side
    always_comb begin
        p1_hit = 1'b0;
        p1_lvl = '0;
        p2_hit = 1'b0;
        p2_lvl = '0;
        for (int lv = LEVELS - 1; lv >= 0; lv--) begin
            if (r_served[lv] < r_len[lv]) begin
                p1_hit = 1'b1;
                p1_lvl = LW'(lv);
            end
            if (r_len[lv] != '0) begin
                p2_hit = 1'b1;
                p2_lvl = LW'(lv);
            end
        end
    end

    assign pick_any = p1_hit | p2_hit;
    assign pick_lvl = p1_hit ? p1_lvl : p2_lvl;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_len    = r_len;
        n_served = r_served;
        n_res    = r_res;
        n_ovalid = r_ovalid;
        row_ctl.cmd = mrqs_pkg::CMD_NOP;
        row_ctl.id  = mrqs_pkg::IDW'(r_id);
        row_sel  = '0;

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                n_res.status    = mrqs_pkg::STAT_NONE;
                n_res.chosen_id = '0;
                case (r_op)
                    mrqs_pkg::OP_ADD: begin
                        if (!lvl_ok) begin
                            n_res.status = mrqs_pkg::STAT_BADLEVEL;
                        end else if (r_len[lvl_idx] == LENW'(QUEUE_DEPTH)) begin
                            n_res.status = mrqs_pkg::STAT_FULL;
                        end else begin
                            row_ctl.cmd      = mrqs_pkg::CMD_LOAD;
                            row_sel[lvl_idx] = 1'b1;
                            n_len[lvl_idx]   = r_len[lvl_idx] + LENW'(1);
                            n_res.status     = mrqs_pkg::STAT_OK;
                        end
                    end
                    mrqs_pkg::OP_PICK: begin
                        for (int lv = 0; lv < LEVELS; lv++) begin
                            if (p1_hit && (LW'(lv) > p1_lvl)) begin
                                n_served[lv] = r_served[lv];
                            end else begin
                                n_served[lv] = '0;
                            end
                        end
                        if (pick_any) begin
                            row_ctl.cmd       = mrqs_pkg::CMD_POP;
                            row_sel[pick_lvl] = 1'b1;
                            n_len[pick_lvl]   = r_len[pick_lvl] - LENW'(1);
                            n_served[pick_lvl] = p1_hit ?
                                (r_served[pick_lvl] + LENW'(1)) : LENW'(1);
                            n_res.status      = mrqs_pkg::STAT_OK;
                            n_res.chosen_id   = mrqs_pkg::IDW'(heads[pick_lvl]);
                        end
                    end
                    mrqs_pkg::OP_REMOVE: begin
                        if (!lvl_ok) begin
                            n_res.status = mrqs_pkg::STAT_BADLEVEL;
                        end else begin
                            row_ctl.cmd      = mrqs_pkg::CMD_MATCH;
                            row_sel[lvl_idx] = 1'b1;
                            n_step           = '0;
                            n_state          = S_PREFIX;
                        end
                    end
                    default: begin
                        n_res.status = mrqs_pkg::STAT_NONE;
                    end
                endcase
            end
            S_PREFIX: begin
                row_ctl.cmd      = mrqs_pkg::CMD_PREFIX;
                row_sel[lvl_idx] = 1'b1;
                if (r_step == SW'(STEPS - 1)) begin
                    n_state = S_SHIFT;
                end else begin
                    n_step = r_step + SW'(1);
                end
            end
            S_SHIFT: begin
                n_state = S_DONE;
                if (found[lvl_idx]) begin
                    row_ctl.cmd      = mrqs_pkg::CMD_SHIFT_HIT;
                    row_sel[lvl_idx] = 1'b1;
                    n_len[lvl_idx]   = r_len[lvl_idx] - LENW'(1);
                    n_res.status     = mrqs_pkg::STAT_OK;
                    n_res.chosen_id  = mrqs_pkg::IDW'(r_id);
                end else begin
                    n_res.status    = mrqs_pkg::STAT_NONE;
                    n_res.chosen_id = '0;
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_ovalid <= 1'b0;
            for (int lv = 0; lv < LEVELS; lv++) begin
                r_len[lv]    <= '0;
                r_served[lv] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_ovalid <= n_ovalid;
            r_len    <= n_len;
            r_served <= n_served;
        end
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_op  <= i_in.op;
            r_id  <= i_in.task_id[SB-1:0];
            r_lvl <= i_in.level;
        end
        r_res <= n_res;
        if (r_state == S_DONE && (!r_ovalid || !i_out_stall)) begin
            r_out <= r_res;
        end
    end

    // one cell row per level
    genvar g;
    generate
        for (g = 0; g < LEVELS; g++) begin : g_row
            mrqs_row #(
                .DEPTH (QUEUE_DEPTH),
                .SB    (SB),
                .LENW  (LENW),
                .STEPS (STEPS),
                .SW    (SW)
            ) u_row (
                .i_clk   (i_clk),
                .i_sel   (row_sel[g]),
                .i_ctl   (row_ctl),
                .i_step  (r_step),
                .i_len   (r_len[g]),
                .o_head  (heads[g]),
                .o_found (found[g])
            );
        end
    endgenerate

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    // checks
    `MRQS_ASSERT_NEXT(a_done_emits, (r_state == S_DONE) && !(r_ovalid && i_out_stall), o_out_valid && (r_state == S_IDLE))
    `MRQS_ASSERT_IMPL(a_fail_zero_id, o_out_valid && (o_out.status != mrqs_pkg::STAT_OK), o_out.chosen_id == '0)
    `MRQS_ASSERT_IMPL(a_prefix_remove, (r_state == S_PREFIX) || (r_state == S_SHIFT), (r_op == mrqs_pkg::OP_REMOVE) && lvl_ok)

endmodule
